/* design/ofp_pkg.sv */
// Shared types, constants and sine table builder for the open-loop FOC PWM block.
package ofp_pkg;

    // Table depth must be a power of two, 64 to 4096
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int DUTY_BITS        = 16;
    localparam int DUTY_CNT_W       = $clog2(DUTY_BITS);

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY_VOLTAGE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_POLE_PAIRS     = CFG_INDEX_W'(1);

    localparam logic [15:0] SUPPLY_RESET = 16'd3072;
    localparam logic [6:0]  POLES_RESET  = 7'd7;

    // Angle step per tick: velocity * 2^24 / (2000 pi), scaled by 2^16
    localparam logic [27:0] ANGLE_STEP_K = 28'd174992711;
    // Reciprocal of 3 for 17-bit numerators
    localparam logic [16:0] THIRD_RECIP  = 17'd43691;
    localparam logic [16:0] SQRT3_Q16    = 17'd113512;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH];

    typedef struct packed {
        logic               opcode;
        logic signed [23:0] velocity;
        logic signed [15:0] quad_voltage;
        logic [15:0]        direct_angle;
    } ofp_in_t;

    typedef struct packed {
        logic [15:0] duty_phase_a;
        logic [15:0] duty_phase_b;
        logic [15:0] duty_phase_c;
        logic [15:0] electrical_angle;
    } ofp_out_t;

    // One Taylor term: t = 1 - x2 * t / div, floored at zero
    function automatic logic [63:0] series_term(input logic [63:0] prod_div);
        logic [63:0] t;
        t = (prod_div >= ONE_Q30) ? 64'd0 : ONE_Q30 - prod_div;
        return t;
    endfunction

    // Quarter-wave sine entry in Q1.15, built in Q30 by a nested Taylor series
    function automatic logic [15:0] sine_entry(input logic [63:0] i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (PI_HALF_Q30 * i) / SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = series_term(((x2 * t) >> 30) / 64'd210);
        t  = series_term(((x2 * t) >> 30) / 64'd156);
        t  = series_term(((x2 * t) >> 30) / 64'd110);
        t  = series_term(((x2 * t) >> 30) / 64'd72);
        t  = series_term(((x2 * t) >> 30) / 64'd42);
        t  = series_term(((x2 * t) >> 30) / 64'd20);
        t  = series_term(((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        return (s > 64'd32767) ? 16'd32767 : s[15:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            rom[i] = sine_entry(64'(i));
        end
        return rom;
    endfunction

endpackage

/* design/open_loop_foc_phase_pwm.sv */
// Top level: open-loop FOC inverse Park/Clarke PWM duty generator.
// Each command word runs on one shared multiplier and one restoring divider under a
// small sequencer; cmd_ready is low while a word is in progress. A velocity tick runs
// six multiplier passes and a direct voltage set three (each a multiply step and a
// take step), then a Uq clamp, two sine ROM reads, then per phase a clamp, a numerator
// step, DUTY_BITS divider steps and a store, and a finish step that loads the result
// register once it is free. The result register lets the next word be accepted while
// a result waits to be taken.
// Configuration writes are taken at any time but are meant for idle periods.
module open_loop_foc_phase_pwm (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  ofp_pkg::ofp_in_t                cmd,
    output logic                            res_valid,
    input  logic                            res_ready,
    output ofp_pkg::ofp_out_t               res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ofp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ofp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ofp_pkg::*;

    localparam int NUM_W = 48 + DUTY_BITS;
    localparam int REM_W = DUTY_BITS + 16;

    typedef enum logic [4:0] {
        ST_IDLE, ST_VEL_MUL, ST_VEL_ADD, ST_ANG_MUL, ST_ANG_TAKE, ST_UQ_MUL, ST_UQ_TAKE,
        ST_CLAMP, ST_COS_RD, ST_COS_TAKE, ST_A_MUL, ST_A_TAKE, ST_B_MUL, ST_B_TAKE,
        ST_S_MUL, ST_S_TAKE, ST_PH_PREP, ST_PH_NUM, ST_DIV, ST_PH_STORE, ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [1:0]              phase_reg;
    logic [DUTY_CNT_W-1:0]   bit_cnt_reg;
    logic                    res_valid_reg;
    ofp_out_t                res_reg;
    logic [15:0]             supply_reg;
    logic [6:0]              poles_reg;
    logic [31:0]             shaft_reg;

    logic signed [23:0]      vel_reg;
    logic [15:0]             ang_reg;
    logic signed [15:0]      uq_reg;
    logic signed [15:0]      sn_reg;
    logic signed [15:0]      cs_reg;
    logic signed [31:0]      a_reg;
    logic signed [31:0]      b_reg;
    logic signed [47:0]      sb_reg;
    logic [47:0]             u_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [DUTY_BITS-1:0]    quo_reg;
    logic [15:0]             duty_reg [3];
    logic signed [61:0]      prod_reg;

    logic signed [32:0]      mul_a;
    logic signed [28:0]      mul_b;
    logic [15:0]             rom_angle;
    logic signed [15:0]      rom_sine;
    logic signed [61:0]      vel_round;
    logic signed [17:0]      uq2;
    logic signed [17:0]      s18;
    logic signed [51:0]      off;
    logic signed [51:0]      a16;
    logic signed [51:0]      sb52;
    logic signed [51:0]      vph;
    logic [47:0]             full;
    logic [NUM_W-1:0]        num;
    logic [REM_W-1:0]        div_sh;
    logic                    res_load;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Load the result register once it is free
    assign res_load = (state_reg == ST_FINISH) && (!res_valid_reg || res_ready);

    // Select operands for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_VEL_MUL:
            begin
                mul_a = 33'(vel_reg);
                mul_b = $signed({1'b0, ANGLE_STEP_K});
            end
            ST_ANG_MUL:
            begin
                mul_a = $signed({1'b0, shaft_reg});
                mul_b = $signed(29'(poles_reg));
            end
            ST_UQ_MUL:
            begin
                mul_a = $signed(33'(supply_reg) + 33'd1);
                mul_b = $signed(29'(THIRD_RECIP));
            end
            ST_A_MUL:
            begin
                mul_a = 33'(uq_reg);
                mul_b = 29'(sn_reg);
            end
            ST_B_MUL:
            begin
                mul_a = 33'(uq_reg);
                mul_b = 29'(cs_reg);
            end
            ST_S_MUL:
            begin
                mul_a = 33'(b_reg);
                mul_b = $signed(29'(SQRT3_Q16));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rom_angle = (state_reg == ST_COS_RD) ? (ang_reg + 16'd16384) : ang_reg;

    ofp_sine_rom u_rom (
        .clk   (clk),
        .angle (rom_angle),
        .sine  (rom_sine)
    );

    // Datapath helpers
    always_comb
    begin
        vel_round = (prod_reg + 62'sd32768) >>> 16;
        uq2       = 18'(uq_reg) <<< 1;
        s18       = $signed({2'b00, supply_reg});
        off       = $signed(52'(supply_reg) << 31);
        a16       = 52'(a_reg) <<< 16;
        sb52      = 52'(sb_reg);
        full      = {supply_reg, 32'd0};
        unique case (phase_reg)
            2'd0:    vph = (a16 <<< 1) + off;
            2'd1:    vph = sb52 - a16 + off;
            default: vph = -a16 - sb52 + off;
        endcase
        num    = (NUM_W'(u_reg) << DUTY_BITS) - NUM_W'(u_reg) + (NUM_W'(supply_reg) << 31);
        div_sh = REM_W'(supply_reg) << bit_cnt_reg;
    end

    // Sequencer, configuration, shaft angle and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 2'd0;
            bit_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            supply_reg    <= SUPPLY_RESET;
            poles_reg     <= POLES_RESET;
            shaft_reg     <= 32'd0;
        end
        else
        begin
            // Take register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SUPPLY_VOLTAGE)
                begin
                    supply_reg <= cfg_data;
                end
                else if (cfg_index == REG_POLE_PAIRS)
                begin
                    poles_reg <= cfg_data[6:0];
                end
            end

            // Drop the result once taken, unless a new one replaces it
            if (res_valid_reg && res_ready && !res_load)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= cmd.opcode ? ST_CLAMP : ST_VEL_MUL;
                    end
                end
                ST_VEL_MUL:  state_reg <= ST_VEL_ADD;
                ST_VEL_ADD:
                begin
                    shaft_reg <= shaft_reg + vel_round[31:0];
                    state_reg <= ST_ANG_MUL;
                end
                ST_ANG_MUL:  state_reg <= ST_ANG_TAKE;
                ST_ANG_TAKE: state_reg <= ST_UQ_MUL;
                ST_UQ_MUL:   state_reg <= ST_UQ_TAKE;
                ST_UQ_TAKE:  state_reg <= ST_CLAMP;
                ST_CLAMP:    state_reg <= ST_COS_RD;
                ST_COS_RD:   state_reg <= ST_COS_TAKE;
                ST_COS_TAKE: state_reg <= ST_A_MUL;
                ST_A_MUL:    state_reg <= ST_A_TAKE;
                ST_A_TAKE:   state_reg <= ST_B_MUL;
                ST_B_MUL:    state_reg <= ST_B_TAKE;
                ST_B_TAKE:   state_reg <= ST_S_MUL;
                ST_S_MUL:    state_reg <= ST_S_TAKE;
                ST_S_TAKE:
                begin
                    phase_reg <= 2'd0;
                    state_reg <= ST_PH_PREP;
                end
                ST_PH_PREP:  state_reg <= ST_PH_NUM;
                ST_PH_NUM:
                begin
                    bit_cnt_reg <= DUTY_CNT_W'(DUTY_BITS - 1);
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg <= ST_PH_STORE;
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    end
                end
                ST_PH_STORE:
                begin
                    if (phase_reg == 2'd2)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 2'd1;
                        state_reg <= ST_PH_PREP;
                    end
                end
                ST_FINISH:
                begin
                    // Hold until the result register is free
                    if (res_load)
                    begin
                        res_valid_reg          <= 1'b1;
                        res_reg.duty_phase_a     <= duty_reg[0];
                        res_reg.duty_phase_b     <= duty_reg[1];
                        res_reg.duty_phase_c     <= duty_reg[2];
                        res_reg.electrical_angle <= ang_reg;
                        state_reg              <= ST_IDLE;
                    end
                end
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

    // Working registers of the datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            ST_IDLE:
            begin
                vel_reg <= cmd.velocity;
                uq_reg  <= cmd.quad_voltage;
                ang_reg <= cmd.direct_angle;
            end
            ST_ANG_TAKE: ang_reg <= prod_reg[31:16];
            ST_UQ_TAKE:  uq_reg  <= $signed(prod_reg[32:17]);
            ST_CLAMP:
            begin
                // Limit Uq to half the supply on either side
                if (uq2 > s18)
                begin
                    uq_reg <= $signed({1'b0, supply_reg[15:1]});
                end
                else if (-uq2 > s18)
                begin
                    uq_reg <= -$signed({1'b0, supply_reg[15:1]});
                end
            end
            ST_COS_RD:   sn_reg <= rom_sine;
            ST_COS_TAKE: cs_reg <= rom_sine;
            ST_A_TAKE:   a_reg  <= -prod_reg[31:0];
            ST_B_TAKE:   b_reg  <= prod_reg[31:0];
            ST_S_TAKE:   sb_reg <= prod_reg[47:0];
            ST_PH_PREP:
            begin
                // Clamp the phase voltage to 0..supply
                if (vph < 0)
                begin
                    u_reg <= 48'd0;
                end
                else if (vph > $signed({4'd0, full}))
                begin
                    u_reg <= full;
                end
                else
                begin
                    u_reg <= vph[47:0];
                end
            end
            ST_PH_NUM:
            begin
                rem_reg <= num[NUM_W-1:32];
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                // One restoring step per cycle
                if (rem_reg >= div_sh)
                begin
                    rem_reg              <= rem_reg - div_sh;
                    quo_reg[bit_cnt_reg] <= 1'b1;
                end
            end
            ST_PH_STORE:
            begin
                duty_reg[phase_reg] <= (supply_reg == 16'd0) ? 16'd0 : 16'(quo_reg);
            end
            default:
            begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("sequencer accepted a word without going busy");

    a_shaft_moves_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_VEL_ADD |=> $stable(shaft_reg))
        else $error("shaft angle changed outside a velocity tick");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result word raised outside the finish step");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> phase_reg != 2'd3)
        else $error("phase counter out of range during divide");
`endif

endmodule

/* design/ofp_sine_rom.sv */
// Quarter-wave sine ROM with quadrant folding; one registered lookup per cycle.
module ofp_sine_rom (
    input  logic               clk,
    input  logic [15:0]        angle,
    output logic signed [15:0] sine
);
    import ofp_pkg::*;

    localparam sine_rom_t ROM = build_sine_rom();

    logic [1:0]            quad;
    logic [14:0]           offset;
    logic [SINE_IDX_W:0]   idx_full;
    logic [15:0]           data_reg;
    logic                  top_reg;
    logic                  neg_reg;
    logic [15:0]           mag;

    // Fold the angle into the first quadrant
    always_comb
    begin
        quad     = angle[15:14];
        offset   = quad[0] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
        idx_full = (SINE_IDX_W+1)'(offset >> (14 - SINE_IDX_W));
    end

    // Read the table and keep the fold flags alongside
    always_ff @(posedge clk)
    begin
        data_reg <= ROM[idx_full[SINE_IDX_W-1:0]];
        top_reg  <= idx_full[SINE_IDX_W];
        neg_reg  <= quad[1];
    end

    // Full quarter turn reads as one; lower half-turn negates
    always_comb
    begin
        mag  = top_reg ? 16'd32767 : data_reg;
        sine = neg_reg ? -$signed(mag) : $signed(mag);
    end

endmodule

/* verif/tb.sv */
// Self-checking testbench for the open-loop FOC phase PWM block.
`timescale 1ns / 1ps

module tb;

    import ofp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] STEP_K = 64'd174992711;
    localparam longint SQRT3_FIX = 113512;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    ofp_in_t cmd;
    logic res_valid;
    logic res_ready;
    ofp_out_t res;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic [15:0] model_supply;
    logic [6:0] model_poles;
    logic [31:0] model_shaft;
    logic [15:0] quarter_rom [SINE_TABLE_DEPTH];

    ofp_out_t duty_queue [$];
    int error_count = 0;
    int result_count = 0;
    int idle_cycles = 0;
    int src_idle_pct;
    int snk_idle_pct;

    open_loop_foc_phase_pwm dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Quarter-wave table built independently in Q30
    function automatic logic [15:0] rom_value(input longint unsigned i);
        longint unsigned divisors [7];
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned d;
        longint unsigned s;
        divisors = '{210, 156, 110, 72, 42, 20, 6};
        x = (64'd1686629713 * i) / SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t = 64'd1073741824;
        foreach (divisors[k])
        begin
            d = ((x2 * t) >> 30) / divisors[k];
            t = (d >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - d;
        end
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        return (s > 64'd32767) ? 16'd32767 : s[15:0];
    endfunction

    function automatic longint quarter_lookup(input logic [14:0] p);
        longint unsigned idx;
        idx = (longint'(p) * SINE_TABLE_DEPTH) >> 14;
        if (idx >= SINE_TABLE_DEPTH)
            return 32767;
        return longint'(quarter_rom[idx]);
    endfunction

    function automatic longint sine_fix(input logic [15:0] a);
        longint v;
        v = a[14] ? quarter_lookup(15'd16384 - {1'b0, a[13:0]})
                  : quarter_lookup({1'b0, a[13:0]});
        return a[15] ? -v : v;
    endfunction

    function automatic logic [15:0] duty_of(input longint v, input longint unsigned full);
        longint unsigned u;
        longint unsigned num;
        if (v < 0)
            v = 0;
        u = longint'(v);
        if (u > full)
            u = full;
        // u * 65535 stays below 2^64; the product is still formed in 128-bit arithmetic
        num = ({64'd0, u} * 128'd65535 + (full >> 1)) / full;
        return num[15:0];
    endfunction

    // Compute expected duties, advancing the shaft angle on velocity ticks
    function automatic ofp_out_t predict_duty(input ofp_in_t w);
        ofp_out_t r;
        longint s;
        longint uq;
        longint v;
        longint p;
        longint q;
        longint sn;
        longint cs;
        longint a;
        longint b;
        longint off;
        logic [31:0] prod;
        logic [15:0] ang;
        s = longint'(model_supply);
        if (w.opcode)
        begin
            uq = longint'(w.quad_voltage);
            ang = w.direct_angle;
        end
        else
        begin
            v = longint'(w.velocity);
            p = v * longint'(STEP_K) + 32768;
            q = (p >= 0) ? (p >>> 16) : -((-p + 65535) >>> 16);
            model_shaft = model_shaft + q[31:0];
            prod = model_shaft * {25'd0, model_poles};
            ang = prod[31:16];
            uq = (s + 1) / 3;
        end
        if (2 * uq > s)
            uq = s / 2;
        else if (-2 * uq > s)
            uq = -(s / 2);
        sn = sine_fix(ang);
        cs = sine_fix(ang + 16'd16384);
        a = -uq * sn;
        b = uq * cs;
        off = s * (longint'(1) << 31);
        if (s == 0)
        begin
            r.duty_phase_a = '0;
            r.duty_phase_b = '0;
            r.duty_phase_c = '0;
        end
        else
        begin
            r.duty_phase_a = duty_of(2 * a * 65536 + off, longint'(s) << 32);
            r.duty_phase_b = duty_of(SQRT3_FIX * b - a * 65536 + off, longint'(s) << 32);
            r.duty_phase_c = duty_of(-a * 65536 - SQRT3_FIX * b + off, longint'(s) << 32);
        end
        r.electrical_angle = ang;
        return r;
    endfunction

    // Send one command word and queue its expected result
    task automatic send_word(input ofp_in_t w);
        while ($urandom_range(99) < src_idle_pct)
            @(posedge clk);
        cmd <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        duty_queue.push_back(predict_duty(w));
        cmd_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(input logic signed [23:0] vel);
        ofp_in_t w;
        w.opcode = 1'b0;
        w.velocity = vel;
        w.quad_voltage = 16'($urandom);
        w.direct_angle = 16'($urandom);
        send_word(w);
    endtask

    task automatic send_direct(input logic signed [15:0] uq, input logic [15:0] ang);
        ofp_in_t w;
        w.opcode = 1'b1;
        w.velocity = 24'($urandom);
        w.quad_voltage = uq;
        w.direct_angle = ang;
        send_word(w);
    endtask

    // Wait until every expected result has been checked, then a settling margin
    task automatic drain();
        while (duty_queue.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_SUPPLY_VOLTAGE)
            model_supply = val;
        else if (idx == REG_POLE_PAIRS)
            model_poles = val[6:0];
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_direct(16'sh0000, 16'h0000);
        send_direct(16'sh7FFF, 16'h0000);
        send_direct(16'sh8000, 16'h4000);
        send_direct(16'sh0100, 16'hFFFF);
        send_direct(-16'sh0100, 16'h8000);
        send_direct(16'sh0300, 16'hC000);
        send_direct(16'sh0200, 16'h3FFF);
        send_tick(24'sh000000);
        send_tick(24'sh7FFFFF);
        send_tick(24'sh800000);
        send_tick(24'sh000100);
        send_tick(-24'sh000100);
        send_tick(24'shFFFFFF);
        send_tick(24'sh000001);
    endtask

    task automatic test_config_extremes();
        drain();
        write_reg(REG_SUPPLY_VOLTAGE, 16'hFFFF);
        write_reg(REG_POLE_PAIRS, 16'd64);
        send_direct(16'sh7FFF, 16'h1234);
        send_direct(16'sh8000, 16'hA000);
        send_tick(24'sh123456);
        drain();
        write_reg(REG_SUPPLY_VOLTAGE, 16'd1);
        write_reg(REG_POLE_PAIRS, 16'd1);
        send_direct(16'sh7FFF, 16'h2000);
        send_tick(24'sh7FFFFF);
        drain();
        // zero supply and zero pole pairs, and two ignored indices
        write_reg(REG_SUPPLY_VOLTAGE, 16'd0);
        write_reg(REG_POLE_PAIRS, 16'd0);
        write_reg(8'd2, 16'hBEEF);
        write_reg(8'hFF, 16'h1234);
        send_tick(24'sh345678);
        send_direct(16'sh0100, 16'h6000);
        drain();
        write_reg(REG_SUPPLY_VOLTAGE, 16'd3072);
        write_reg(REG_POLE_PAIRS, 16'd7);
    endtask

    task automatic random_words(input int n);
        ofp_in_t w;
        for (int i = 0; i < n; i++)
        begin
            w.opcode = 1'($urandom);
            w.velocity = 24'($urandom);
            w.quad_voltage = 16'($urandom);
            w.direct_angle = 16'($urandom);
            if ($urandom_range(3) == 0)
                w.velocity = $signed(24'($urandom_range(4000))) - 24'sd2000;
            send_word(w);
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 87 : 0;
            snk_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 31 : 0;
            drain();
            write_reg(REG_SUPPLY_VOLTAGE, 16'($urandom_range(65535, 1)));
            write_reg(REG_POLE_PAIRS, 16'($urandom_range(64, 1)));
            random_words(240);
        end
    endtask

    // Drive the result ready with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        ofp_out_t exp_word;
        if (rst_n && res_valid && res_ready)
        begin
            result_count++;
            if (duty_queue.size() == 0)
            begin
                $error("result with no expectation: %h", res);
                error_count++;
            end
            else
            begin
                exp_word = duty_queue.pop_front();
                if (res.duty_phase_a !== exp_word.duty_phase_a)
                begin
                    $error("duty_phase_a exp %0d got %0d", exp_word.duty_phase_a,
                           res.duty_phase_a);
                    error_count++;
                end
                if (res.duty_phase_b !== exp_word.duty_phase_b)
                begin
                    $error("duty_phase_b exp %0d got %0d", exp_word.duty_phase_b,
                           res.duty_phase_b);
                    error_count++;
                end
                if (res.duty_phase_c !== exp_word.duty_phase_c)
                begin
                    $error("duty_phase_c exp %0d got %0d", exp_word.duty_phase_c,
                           res.duty_phase_c);
                    error_count++;
                end
                if (res.electrical_angle !== exp_word.electrical_angle)
                begin
                    $error("electrical_angle exp %0d got %0d", exp_word.electrical_angle,
                           res.electrical_angle);
                    error_count++;
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", duty_queue.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        model_supply = SUPPLY_RESET;
        model_poles = POLES_RESET;
        model_shaft = '0;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
            quarter_rom[i] = rom_value(i);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_random();
        drain();
        $display("checked %0d results over directed extremes, config corners", result_count);
        $display("and randomized ticks and direct sets under three stall mixes");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
design/ofp_pkg.sv
design/ofp_sine_rom.sv
design/open_loop_foc_phase_pwm.sv
verif/tb.sv
